// File: rtl/lc3ie_pkg.sv
// shared types, constants and helper functions for the lc-3 execute unit
// no dependencies; imported by lc3ie_rf, lc3ie_mem and lc3_instruction_execute
package lc3ie_pkg;

    // machine word and memory geometry
    localparam int WORD_W    = 16;
    localparam int ADDR_BITS = 16;
    localparam int MEM_WORDS = 1 << ADDR_BITS;
    localparam int REG_CNT   = 8;
    localparam int REG_IDX_W = 3;

    // stream and register port widths
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 88;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // register map
    localparam logic [PADDR_W-1:0] REG_START_PC = 3'd0;
    localparam logic [WORD_W-1:0]  START_PC_RESET = 16'h3000;

    // condition code values
    localparam logic [2:0] CC_P = 3'd1;
    localparam logic [2:0] CC_Z = 3'd2;
    localparam logic [2:0] CC_N = 3'd4;

    // index of the link register
    localparam logic [REG_IDX_W-1:0] LINK_REG = 3'd7;

    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [ADDR_BITS-1:0] maddr_t;
    typedef logic [REG_IDX_W-1:0] ridx_t;

    // standard opcode map
    typedef enum logic [3:0] {
        OP_BR   = 4'h0,
        OP_ADD  = 4'h1,
        OP_LD   = 4'h2,
        OP_ST   = 4'h3,
        OP_JSR  = 4'h4,
        OP_AND  = 4'h5,
        OP_LDR  = 4'h6,
        OP_STR  = 4'h7,
        OP_RTI  = 4'h8,
        OP_NOT  = 4'h9,
        OP_LDI  = 4'hA,
        OP_STI  = 4'hB,
        OP_JMP  = 4'hC,
        OP_RES  = 4'hD,
        OP_LEA  = 4'hE,
        OP_TRAP = 4'hF
    } opcode_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MEM
    } exec_state_t;

    // register file read request (two ports)
    typedef struct packed {
        logic  rd_en;
        ridx_t addr_a;
        ridx_t addr_b;
    } rf_rd_t;

    // register file write request
    typedef struct packed {
        logic  wr_en;
        ridx_t addr;
        word_t data;
    } rf_wr_t;

    // main memory request, one read and one write port
    typedef struct packed {
        logic   rd_en;
        maddr_t rd_addr;
        logic   wr_en;
        maddr_t wr_addr;
        word_t  wr_data;
    } mem_req_t;

    // result word, first field in the highest bits, last field in the lowest bits
    typedef struct packed {
        logic        illegal_op;
        logic [7:0]  trap_vector;
        logic        trap_taken;
        word_t       mem_data;
        word_t       mem_addr;
        logic        mem_written;
        word_t       reg_value;
        ridx_t       reg_index;
        logic        reg_written;
        logic [2:0]  cond_code;
        word_t       next_pc;
    } exec_result_t;

    // sign extension of instruction offset fields
    function automatic word_t sext5(input word_t ir);
        return {{11{ir[4]}}, ir[4:0]};
    endfunction

    function automatic word_t sext6(input word_t ir);
        return {{10{ir[5]}}, ir[5:0]};
    endfunction

    function automatic word_t sext9(input word_t ir);
        return {{7{ir[8]}}, ir[8:0]};
    endfunction

    function automatic word_t sext11(input word_t ir);
        return {{5{ir[10]}}, ir[10:0]};
    endfunction

    // condition code from a written value
    function automatic logic [2:0] cc_of(input word_t v);
        logic [2:0] cc;
        if (v == '0)
            cc = CC_Z;
        else if (v[WORD_W-1])
            cc = CC_N;
        else
            cc = CC_P;
        return cc;
    endfunction

endpackage

// File: rtl/lc3ie_rf.sv
// general register file: eight words, two registered read ports, one write port
// depends on lc3ie_pkg
module lc3ie_rf
    import lc3ie_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  rf_rd_t rd,
    input  rf_wr_t wr,
    output word_t  rd_a,
    output word_t  rd_b
);

    word_t                regs_mem [REG_CNT];
    logic [REG_CNT-1:0]   vld_reg;
    word_t                rd_a_reg;
    word_t                rd_b_reg;

    // per-entry written marks, an unwritten entry reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr.wr_en)
        begin
            vld_reg[wr.addr] <= 1'b1;
        end
    end

    // storage write
    always_ff @(posedge clk)
    begin
        if (wr.wr_en)
        begin
            regs_mem[wr.addr] <= wr.data;
        end
    end

    // registered reads, held until the next request
    always_ff @(posedge clk)
    begin
        if (rd.rd_en)
        begin
            rd_a_reg <= vld_reg[rd.addr_a] ? regs_mem[rd.addr_a] : '0;
            rd_b_reg <= vld_reg[rd.addr_b] ? regs_mem[rd.addr_b] : '0;
        end
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

// File: rtl/lc3ie_mem.sv
// main word memory: synchronous, one read port with registered data, one write port
// depends on lc3ie_pkg
module lc3ie_mem
    import lc3ie_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output word_t    rd_data
);

    word_t mem_array [MEM_WORDS];
    word_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_array[req.wr_addr] <= req.wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem_array[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/lc3_instruction_execute.sv
// lc-3 execute unit top level: input buffer, sequencer, pc and condition code,
// result register; depends on lc3ie_pkg, lc3ie_rf and lc3ie_mem
//
// usage
// - input stream s_*: s_tuser is func (0 execute s_tdata instr, 1 load a memory word);
//   each accepted word produces exactly one result word on m_*
// - output stream m_*: next pc, condition code, register write, store, trap and
//   illegal-opcode report of the item
// - apb port: register 0 is start_pc; writing it also loads the pc at once.
//   write only while no item is in flight
// - steps: a memory load finishes in the idle step; branch, alu, lea, jumps, trap,
//   ld, st, str and sti fetch in idle and finish in exec; ldi and ldr add a mem step
// - the sequencer works one item at a time, the pace set by the single read port of
//   the main memory and the registered reads of the register file
// - a new word is taken in the cycle the current one finishes, so a one-word input
//   buffer keeps the sequencer fed
// - when m_tready is low a full result register holds; the finished item waits in its
//   last step and commits nothing until the result register is free
// - reset: pc = start_pc = 0x3000, condition code z, registers read as zero,
//   memory contents undefined until loaded; no clearing pass
module lc3_instruction_execute
    import lc3ie_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // instr[15:0], load_addr[31:16], load_data[47:32]
    input  logic                  s_tuser,   // func[0]
    // output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // next_pc[15:0], cond_code[18:16],
                                             // reg_written[19], reg_index[22:20],
                                             // reg_value[38:23], mem_written[39],
                                             // mem_addr[55:40], mem_data[71:56],
                                             // trap_taken[72], trap_vector[80:73],
                                             // illegal_op[81], zero[87:82]
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready
);

    localparam int OUT_PAD_W = OUT_DATA_W - $bits(exec_result_t);

    // state and buffers
    exec_state_t  state_reg, state_next;
    word_t        start_pc_reg;
    word_t        pc_reg;
    logic [2:0]   cc_reg;
    logic         buf_valid_reg;
    logic         buf_func_reg;
    word_t        buf_instr_reg;
    word_t        buf_laddr_reg;
    word_t        buf_ldata_reg;
    logic         out_valid_reg;
    exec_result_t out_data_reg;

    // datapath signals
    rf_rd_t       rf_rd;
    rf_wr_t       rf_wr;
    mem_req_t     mem_req;
    word_t        rf_a;
    word_t        rf_b;
    word_t        mem_q;
    exec_result_t res;
    logic         finish;
    logic         slot_free;
    logic         done;
    logic         set_cc;
    logic         cfg_wr;
    opcode_t      op;
    word_t        ir;
    ridx_t        dr;
    word_t        pc_inc;
    word_t        addr9;
    word_t        addr6;
    word_t        opb;
    word_t        jsr_target;

    lc3ie_rf u_rf (
        .clk   (clk),
        .rst_n (rst_n),
        .rd    (rf_rd),
        .wr    (rf_wr),
        .rd_a  (rf_a),
        .rd_b  (rf_b)
    );

    lc3ie_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_q)
    );

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_START_PC);

    always_comb
    begin
        prdata = '0;
        if (paddr == REG_START_PC)
        begin
            prdata = {{(PDATA_W-WORD_W){1'b0}}, start_pc_reg};
        end
    end

    // decode helpers
    assign ir         = buf_instr_reg;
    assign op         = opcode_t'(ir[15:12]);
    assign dr         = ir[11:9];
    assign pc_inc     = pc_reg + 16'd1;
    assign addr9      = pc_inc + sext9(ir);
    assign addr6      = rf_a + sext6(ir);
    assign opb        = ir[5] ? sext5(ir) : rf_b;
    assign jsr_target = ir[11] ? (pc_inc + sext11(ir)) : rf_a;
    assign slot_free  = !out_valid_reg || m_tready;

    // sequencer: next state, result and memory requests
    always_comb
    begin
        state_next = state_reg;
        done       = 1'b0;
        set_cc     = 1'b0;
        rf_rd      = '0;
        mem_req    = '0;
        res        = '0;
        res.next_pc   = pc_reg;
        res.cond_code = cc_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (buf_valid_reg)
                begin
                    if (buf_func_reg)
                    begin
                        // memory load word: write and report unchanged state
                        done = 1'b1;
                    end
                    else
                    begin
                        // fetch operands and the pc-relative word
                        rf_rd.rd_en  = 1'b1;
                        rf_rd.addr_a = ir[8:6];
                        rf_rd.addr_b = (op == OP_ST || op == OP_STI || op == OP_STR) ?
                                       dr : ir[2:0];
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = addr9[ADDR_BITS-1:0];
                        state_next      = ST_EXEC;
                    end
                end
            end

            ST_EXEC:
            begin
                res.next_pc = pc_inc;
                done        = 1'b1;
                case (op)
                    OP_BR:
                    begin
                        if (|(ir[11:9] & cc_reg))
                            res.next_pc = addr9;
                    end
                    OP_ADD:
                    begin
                        res.reg_written = 1'b1;
                        res.reg_index   = dr;
                        res.reg_value   = rf_a + opb;
                        set_cc          = 1'b1;
                    end
                    OP_AND:
                    begin
                        res.reg_written = 1'b1;
                        res.reg_index   = dr;
                        res.reg_value   = rf_a & opb;
                        set_cc          = 1'b1;
                    end
                    OP_NOT:
                    begin
                        res.reg_written = 1'b1;
                        res.reg_index   = dr;
                        res.reg_value   = ~rf_a;
                        set_cc          = 1'b1;
                    end
                    OP_LEA:
                    begin
                        res.reg_written = 1'b1;
                        res.reg_index   = dr;
                        res.reg_value   = addr9;
                        set_cc          = 1'b1;
                    end
                    OP_LD:
                    begin
                        res.reg_written = 1'b1;
                        res.reg_index   = dr;
                        res.reg_value   = mem_q;
                        set_cc          = 1'b1;
                    end
                    OP_LDI:
                    begin
                        // second read through the pointer word
                        done            = 1'b0;
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = mem_q[ADDR_BITS-1:0];
                        state_next      = ST_MEM;
                    end
                    OP_LDR:
                    begin
                        done            = 1'b0;
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = addr6[ADDR_BITS-1:0];
                        state_next      = ST_MEM;
                    end
                    OP_ST:
                    begin
                        res.mem_written = 1'b1;
                        res.mem_addr    = addr9;
                        res.mem_data    = rf_b;
                    end
                    OP_STI:
                    begin
                        res.mem_written = 1'b1;
                        res.mem_addr    = mem_q;
                        res.mem_data    = rf_b;
                    end
                    OP_STR:
                    begin
                        res.mem_written = 1'b1;
                        res.mem_addr    = addr6;
                        res.mem_data    = rf_b;
                    end
                    OP_JMP:
                    begin
                        res.next_pc = rf_a;
                    end
                    OP_JSR:
                    begin
                        // target taken from the old base before the link write
                        res.reg_written = 1'b1;
                        res.reg_index   = LINK_REG;
                        res.reg_value   = pc_inc;
                        res.next_pc     = jsr_target;
                    end
                    OP_TRAP:
                    begin
                        res.reg_written = 1'b1;
                        res.reg_index   = LINK_REG;
                        res.reg_value   = pc_inc;
                        res.trap_taken  = 1'b1;
                        res.trap_vector = ir[7:0];
                    end
                    default:
                    begin
                        // rti and the reserved opcode
                        res.illegal_op = 1'b1;
                    end
                endcase
            end

            ST_MEM:
            begin
                res.next_pc     = pc_inc;
                res.reg_written = 1'b1;
                res.reg_index   = dr;
                res.reg_value   = mem_q;
                set_cc          = 1'b1;
                done            = 1'b1;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (set_cc)
        begin
            res.cond_code = cc_of(res.reg_value);
        end

        // commit only when the result register can take the word
        finish = done && slot_free;
        if (finish)
        begin
            state_next = ST_IDLE;
        end

        rf_wr.wr_en = finish && res.reg_written;
        rf_wr.addr  = res.reg_index;
        rf_wr.data  = res.reg_value;

        mem_req.wr_en   = finish && (res.mem_written || (state_reg == ST_IDLE));
        mem_req.wr_addr = res.mem_written ? res.mem_addr[ADDR_BITS-1:0] :
                                            buf_laddr_reg[ADDR_BITS-1:0];
        mem_req.wr_data = res.mem_written ? res.mem_data : buf_ldata_reg;
    end

    // input buffer is freed in the cycle its word finishes
    assign s_tready = !buf_valid_reg || finish;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_pc_reg  <= START_PC_RESET;
            pc_reg        <= START_PC_RESET;
            cc_reg        <= CC_Z;
            buf_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // pc and condition code
            if (cfg_wr)
            begin
                start_pc_reg <= pwdata[WORD_W-1:0];
                pc_reg       <= pwdata[WORD_W-1:0];
            end
            else if (finish)
            begin
                pc_reg <= res.next_pc;
                cc_reg <= res.cond_code;
            end

            // input buffer occupancy
            if (s_tvalid && s_tready)
                buf_valid_reg <= 1'b1;
            else if (finish)
                buf_valid_reg <= 1'b0;

            // result register occupancy
            if (finish)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // input buffer payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            buf_func_reg  <= s_tuser;
            buf_instr_reg <= s_tdata[15:0];
            buf_laddr_reg <= s_tdata[31:16];
            buf_ldata_reg <= s_tdata[47:32];
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_data_reg};

endmodule
